[sv/rcap_pkg.sv]
package rcap_pkg;

    // build-time limits on the parse
    localparam int MAX_ARGS = 64;
    localparam int LEN_BITS = 16;

    localparam int ARG_LIMIT = (MAX_ARGS < 64) ? MAX_ARGS : 64;
    localparam logic [16:0] ARG_LIMIT_W = 17'(ARG_LIMIT);
    localparam logic [16:0] LEN_CAP =
        (LEN_BITS >= 16) ? 17'd65535 : 17'((64'd1 << LEN_BITS) - 64'd1);

    // accumulator saturates one above the largest legal number
    localparam logic [16:0] ACC_SAT = 17'd65536;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [0:0] CFG_IDX_MAX_ARGS = 1'd0;
    localparam logic [0:0] CFG_IDX_MAX_LEN  = 1'd1;

    localparam logic [6:0]  MAX_ARGS_RST = 7'd64;
    localparam logic [15:0] MAX_LEN_RST  = 16'd65535;

    typedef enum logic [2:0] {
        PH_STAR   = 3'd0,
        PH_COUNT  = 3'd1,
        PH_LF     = 3'd2,
        PH_DOLLAR = 3'd3,
        PH_LEN    = 3'd4,
        PH_DATA   = 3'd5,
        PH_CR     = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        NEXT_DOLLAR = 2'd0,
        NEXT_DATA   = 2'd1,
        NEXT_END    = 2'd2
    } t_after;

    typedef enum logic [2:0] {
        EV_FRAME    = 3'd0,
        EV_COUNT    = 3'd1,
        EV_LENGTH   = 3'd2,
        EV_ARG_BYTE = 3'd3,
        EV_COMPLETE = 3'd4,
        EV_ERROR    = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_UNEXPECTED = 2'd1,
        ERR_COUNT      = 2'd2,
        ERR_LENGTH     = 2'd3
    } t_err;

    typedef struct packed {
        logic [6:0]  max_arg_count;
        logic [15:0] max_string_length;
    } t_cfg;

    typedef struct packed {
        t_event      event_kind;
        logic [7:0]  out_byte;
        logic [5:0]  arg_position;
        logic [15:0] number_value;
        logic        arg_end;
        t_err        error_code;
    } t_result;

endpackage

[sv/rcap_in_if.sv]
interface rcap_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

[sv/rcap_out_if.sv]
interface rcap_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [7:0]  out_byte;
    logic [5:0]  arg_position;
    logic [15:0] number_value;
    logic        arg_end;
    logic [1:0]  error_code;

    modport source (output valid, output event_kind, output out_byte,
                    output arg_position, output number_value, output arg_end,
                    output error_code, input ready);
    modport sink (input valid, input event_kind, input out_byte,
                  input arg_position, input number_value, input arg_end,
                  input error_code, output ready);
endinterface

[sv/resp_command_array_parser_core.sv]
// A result item is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one byte per cycle while the skid entry is empty; the parse state is a single register stage.
// A two-entry output buffer keeps ready high until its skid entry fills during an output stall.
// Reset (synchronous, active low): parser waits for '*', output buffer empty,
// max_arg_count = 64, max_string_length = 65535.
module resp_command_array_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    rcap_in_if.sink     i_req,
    rcap_out_if.source  o_evt
);
    import rcap_pkg::*;

    logic [6:0]  r_max_arg_count;
    logic [15:0] r_max_str_len;
    t_cfg        w_cfg;

    t_result     w_result;
    logic        w_take;
    logic        w_out_pop;

    logic        r_out_valid, n_out_valid;
    logic        r_skid_valid, n_skid_valid;
    t_result     r_out, r_skid;
    logic        w_load_out;
    logic        w_load_skid;
    logic        w_out_from_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_arg_count <= MAX_ARGS_RST;
            r_max_str_len   <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_MAX_ARGS: r_max_arg_count <= i_cfg_data[6:0];
                CFG_IDX_MAX_LEN:  r_max_str_len   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cfg.max_arg_count     = r_max_arg_count;
    assign w_cfg.max_string_length = r_max_str_len;

    assign i_req.ready = !r_skid_valid;
    assign w_take      = i_req.valid && !r_skid_valid;
    assign w_out_pop   = r_out_valid && o_evt.ready;

    rcap_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_take   (w_take),
        .i_byte   (i_req.in_byte),
        .o_result (w_result)
    );

    always_comb begin
        n_out_valid     = r_out_valid;
        n_skid_valid    = r_skid_valid;
        w_load_out      = 1'b0;
        w_load_skid     = 1'b0;
        w_out_from_skid = 1'b0;
        if (!r_out_valid || w_out_pop) begin
            if (r_skid_valid) begin
                w_load_out      = 1'b1;
                w_out_from_skid = 1'b1;
                n_out_valid     = 1'b1;
                n_skid_valid    = 1'b0;
            end else begin
                w_load_out  = w_take;
                n_out_valid = w_take;
            end
        end else if (w_take) begin
            w_load_skid  = 1'b1;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= w_out_from_skid ? r_skid : w_result;
        end
        if (w_load_skid) begin
            r_skid <= w_result;
        end
    end

    assign o_evt.valid        = r_out_valid;
    assign o_evt.event_kind   = r_out.event_kind;
    assign o_evt.out_byte     = r_out.out_byte;
    assign o_evt.arg_position = r_out.arg_position;
    assign o_evt.number_value = r_out.number_value;
    assign o_evt.arg_end      = r_out.arg_end;
    assign o_evt.error_code   = r_out.error_code;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !o_evt.ready))
        else $error("skid filled without an output stall");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && o_evt.event_kind == EV_ERROR)
        |-> (o_evt.arg_position == 6'd0 && o_evt.number_value == 16'd0 && !o_evt.arg_end))
        else $error("error item carries position, number or end mark");

    a_error_code_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt.valid |-> ((o_evt.error_code != ERR_NONE) == (o_evt.event_kind == EV_ERROR)))
        else $error("error code and event kind disagree");

endmodule

[sv/rcap_parser.sv]
module rcap_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rcap_pkg::t_cfg   i_cfg,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    output rcap_pkg::t_result o_result
);
    import rcap_pkg::*;

    typedef enum logic [3:0] {
        ACT_STAR,
        ACT_DIGIT,
        ACT_COUNT_OK,
        ACT_LEN_OK,
        ACT_DOLLAR,
        ACT_CR,
        ACT_LF_END,
        ACT_LF_EMPTY,
        ACT_LF_DATA,
        ACT_LF_DOLLAR,
        ACT_DATA,
        ACT_ERR_UNEXP,
        ACT_ERR_COUNT,
        ACT_ERR_LEN
    } t_action;

    t_phase      r_phase, n_phase;
    t_after      r_after, n_after;
    logic [16:0] r_accum, n_accum;
    logic [6:0]  r_arg_total, n_arg_total;
    logic [5:0]  r_arg_index, n_arg_index;
    logic [15:0] r_str_len, n_str_len;
    logic [15:0] r_bytes_rcvd, n_bytes_rcvd;

    t_action     w_act;
    logic        w_is_digit;
    logic [7:0]  w_diff;
    logic [3:0]  w_digit;
    logic [20:0] w_mul;
    logic [16:0] w_acc_sat;
    logic        w_count_bad;
    logic        w_len_bad;
    logic [15:0] w_bytes_next;
    logic        w_data_end;
    logic        w_last_arg;

    assign w_is_digit   = i_byte inside {[CH_ZERO:CH_NINE]};
    assign w_diff       = i_byte - CH_ZERO;
    assign w_digit      = w_diff[3:0];
    // accum * 10 + digit as two shifts
    assign w_mul        = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0}
                        + {17'd0, w_digit};
    assign w_acc_sat    = (w_mul > {4'd0, ACC_SAT}) ? ACC_SAT : w_mul[16:0];
    assign w_count_bad  = (r_accum == 17'd0) || (r_accum > {10'd0, i_cfg.max_arg_count})
                        || (r_accum > ARG_LIMIT_W);
    assign w_len_bad    = (r_accum > {1'b0, i_cfg.max_string_length}) || (r_accum > LEN_CAP);
    assign w_bytes_next = r_bytes_rcvd + 16'd1;
    assign w_data_end   = w_bytes_next >= r_str_len;
    assign w_last_arg   = ({1'b0, r_arg_index} + 7'd1) >= r_arg_total;

    always_comb begin
        w_act = ACT_ERR_UNEXP;
        case (r_phase)
            PH_STAR: begin
                if (i_byte == CH_STAR) w_act = ACT_STAR;
            end
            PH_COUNT: begin
                if (w_is_digit) w_act = ACT_DIGIT;
                else if (i_byte == CH_CR) w_act = w_count_bad ? ACT_ERR_COUNT : ACT_COUNT_OK;
            end
            PH_LEN: begin
                if (w_is_digit) w_act = ACT_DIGIT;
                else if (i_byte == CH_CR) w_act = w_len_bad ? ACT_ERR_LEN : ACT_LEN_OK;
            end
            PH_DOLLAR: begin
                if (i_byte == CH_DOLLAR) w_act = ACT_DOLLAR;
            end
            PH_CR: begin
                if (i_byte == CH_CR) w_act = ACT_CR;
            end
            PH_LF: begin
                if (i_byte == CH_LF) begin
                    case (r_after)
                        NEXT_END:  w_act = ACT_LF_END;
                        NEXT_DATA: w_act = (r_str_len == 16'd0) ? ACT_LF_EMPTY : ACT_LF_DATA;
                        default:   w_act = ACT_LF_DOLLAR;
                    endcase
                end
            end
            PH_DATA: w_act = ACT_DATA;
            default: w_act = ACT_ERR_UNEXP;
        endcase
    end

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_after      = r_after;
        n_accum      = r_accum;
        n_arg_total  = r_arg_total;
        n_arg_index  = r_arg_index;
        n_str_len    = r_str_len;
        n_bytes_rcvd = r_bytes_rcvd;
        case (w_act)
            ACT_STAR: begin
                n_phase = PH_COUNT;
                n_accum = 17'd0;
            end
            ACT_DIGIT: n_accum = w_acc_sat;
            ACT_COUNT_OK: begin
                n_arg_total = r_accum[6:0];
                n_arg_index = 6'd0;
                n_accum     = 17'd0;
                n_after     = NEXT_DOLLAR;
                n_phase     = PH_LF;
            end
            ACT_LEN_OK: begin
                n_str_len    = r_accum[15:0];
                n_bytes_rcvd = 16'd0;
                n_accum      = 17'd0;
                n_after      = NEXT_DATA;
                n_phase      = PH_LF;
            end
            ACT_DOLLAR: begin
                n_phase = PH_LEN;
                n_accum = 17'd0;
            end
            ACT_CR:        n_phase = PH_LF;
            ACT_LF_DATA:   n_phase = PH_DATA;
            ACT_LF_DOLLAR: n_phase = PH_DOLLAR;
            ACT_LF_EMPTY, ACT_DATA: begin
                n_bytes_rcvd = w_bytes_next;
                if (w_act == ACT_LF_EMPTY || w_data_end) begin
                    n_str_len    = (w_act == ACT_DATA) ? 16'd0 : r_str_len;
                    n_bytes_rcvd = (w_act == ACT_DATA) ? 16'd0 : r_bytes_rcvd;
                    n_phase      = PH_CR;
                    if (w_last_arg) begin
                        n_after = NEXT_END;
                    end else begin
                        n_arg_index = r_arg_index + 6'd1;
                        n_after     = NEXT_DOLLAR;
                    end
                end
            end
            default: begin
                // request complete or any error: back to waiting for '*'
                n_phase      = PH_STAR;
                n_after      = NEXT_DOLLAR;
                n_accum      = 17'd0;
                n_arg_total  = 7'd0;
                n_arg_index  = 6'd0;
                n_str_len    = 16'd0;
                n_bytes_rcvd = 16'd0;
            end
        endcase
    end

    // result item
    always_comb begin
        o_result.event_kind   = EV_FRAME;
        o_result.out_byte     = i_byte;
        o_result.arg_position = r_arg_index;
        o_result.number_value = 16'd0;
        o_result.arg_end      = 1'b0;
        o_result.error_code   = ERR_NONE;
        case (w_act)
            ACT_COUNT_OK: begin
                o_result.event_kind   = EV_COUNT;
                o_result.arg_position = 6'd0;
                o_result.number_value = r_accum[15:0];
            end
            ACT_LEN_OK: begin
                o_result.event_kind   = EV_LENGTH;
                o_result.number_value = r_accum[15:0];
            end
            ACT_LF_EMPTY: o_result.arg_end = 1'b1;
            ACT_DATA: begin
                o_result.event_kind = EV_ARG_BYTE;
                o_result.arg_end    = w_data_end;
            end
            ACT_LF_END: begin
                o_result.event_kind   = EV_COMPLETE;
                o_result.arg_position = 6'd0;
            end
            ACT_ERR_UNEXP: begin
                o_result.event_kind   = EV_ERROR;
                o_result.arg_position = 6'd0;
                o_result.error_code   = ERR_UNEXPECTED;
            end
            ACT_ERR_COUNT: begin
                o_result.event_kind   = EV_ERROR;
                o_result.arg_position = 6'd0;
                o_result.error_code   = ERR_COUNT;
            end
            ACT_ERR_LEN: begin
                o_result.event_kind   = EV_ERROR;
                o_result.arg_position = 6'd0;
                o_result.error_code   = ERR_LENGTH;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_STAR;
            r_after      <= NEXT_DOLLAR;
            r_accum      <= 17'd0;
            r_arg_total  <= 7'd0;
            r_arg_index  <= 6'd0;
            r_str_len    <= 16'd0;
            r_bytes_rcvd <= 16'd0;
        end else if (i_take) begin
            r_phase      <= n_phase;
            r_after      <= n_after;
            r_accum      <= n_accum;
            r_arg_total  <= n_arg_total;
            r_arg_index  <= n_arg_index;
            r_str_len    <= n_str_len;
            r_bytes_rcvd <= n_bytes_rcvd;
        end
    end

    a_accum_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_accum <= ACC_SAT)
        else $error("accumulator above saturation value");

    a_index_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA || r_phase == PH_DOLLAR || r_phase == PH_LEN)
        |-> ({1'b0, r_arg_index} < r_arg_total))
        else $error("argument index past argument count");

    a_data_needs_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_str_len != 16'd0 && r_bytes_rcvd < r_str_len))
        else $error("data phase without bytes outstanding");

endmodule
